FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ppp_pkg.sv
// types, constants and arithmetic helpers of the point projection pipeline
package ppp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W - 1;  // focal * |coord| never reaches 2^PROD_W
  localparam int SUM_W     = COORD_W + 3;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [COORD_W-1:0] mag_t;
  typedef logic        [COORD_W-2:0] rem_t;
  typedef logic        [PROD_W-1:0]  prod_t;
  typedef logic        [2*COORD_W-1:0] wide_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [1:0]         status_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_SAT  = 2'd1;
  localparam status_t ST_ZERO = 2'd2;

  localparam cfg_idx_t CFG_FOCAL    = 2'd0;
  localparam cfg_idx_t CFG_CENTER_X = 2'd1;
  localparam cfg_idx_t CFG_CENTER_Y = 2'd2;

  localparam mag_t   FOCAL_RESET = mag_t'(1) << FRAC_BITS;
  localparam coord_t COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
  } meta_t;

  // numerator bits leave at the top while quotient bits enter at the bottom
  typedef struct packed {
    prod_t nq;
    rem_t  rem;
  } div_lane_t;

  typedef struct packed {
    div_lane_t lx;
    div_lane_t ly;
    mag_t      den;
    meta_t     meta;
  } div_word_t;

  typedef struct packed {
    prod_t qx;
    prod_t qy;
    meta_t meta;
  } quo_t;

  typedef struct packed {
    coord_t v;
    logic   sat;
  } coord_res_t;

  typedef struct packed {
    coord_t  proj_x;
    coord_t  proj_y;
    status_t status;
  } result_t;

  function automatic mag_t mag_of(coord_t v);
    coord_t n;
    n = -v;
    return v[COORD_W-1] ? mag_t'(n) : mag_t'(v);
  endfunction

  // one restoring step: shift in a numerator bit, subtract when it fits
  function automatic div_lane_t div_step(div_lane_t l, mag_t d);
    mag_t      rs;
    mag_t      diff;
    logic      take;
    div_lane_t o;
    rs    = {l.rem, l.nq[PROD_W-1]};
    take  = (rs >= d);
    diff  = rs - d;
    o.rem = take ? diff[COORD_W-2:0] : rs[COORD_W-2:0];
    o.nq  = {l.nq[PROD_W-2:0], take};
    return o;
  endfunction

  // apply sign, add center, clamp to the coordinate range
  function automatic coord_res_t finish(prod_t q, logic neg, coord_t c);
    logic       big;
    logic       ovf;
    sum_t       mq;
    sum_t       sum;
    coord_res_t r;
    big = |q[PROD_W-1:COORD_W+1];
    mq  = sum_t'({2'b00, q[COORD_W:0]});
    if (neg) begin
      mq = -mq;
    end
    sum = mq + sum_t'(c);
    ovf = !((&sum[SUM_W-1:COORD_W-1]) || !(|sum[SUM_W-1:COORD_W-1]));
    if (big) begin
      r.v   = neg ? COORD_MIN : COORD_MAX;
      r.sat = 1'b1;
    end else if (ovf) begin
      r.v   = sum[SUM_W-1] ? COORD_MIN : COORD_MAX;
      r.sat = 1'b1;
    end else begin
      r.v   = sum[COORD_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: design/ppp_ifs.sv
// valid/ready channel interfaces for points in and projections out
interface ppp_point_if;
  logic            valid;
  logic            ready;
  ppp_pkg::coord_t point_x;
  ppp_pkg::coord_t point_y;
  ppp_pkg::coord_t point_z;

  modport source(output valid, output point_x, output point_y, output point_z,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input point_z,
               output ready);
endinterface

interface ppp_proj_if;
  logic             valid;
  logic             ready;
  ppp_pkg::coord_t  proj_x;
  ppp_pkg::coord_t  proj_y;
  ppp_pkg::status_t status;

  modport source(output valid, output proj_x, output proj_y, output status,
                 input ready);
  modport sink(input valid, input proj_x, input proj_y, input status,
               output ready);
endinterface

FILE: design/ppp_mul.sv
// front end: sign split and zero detect, then focal length products
module ppp_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  ppp_pkg::coord_t    point_x,
  input  ppp_pkg::coord_t    point_y,
  input  ppp_pkg::coord_t    point_z,
  input  ppp_pkg::mag_t      focal,
  output logic               out_valid,
  output ppp_pkg::div_word_t out_word
);

  logic             v1_r;
  ppp_pkg::mag_t    mx1_r, my1_r, mz1_r;
  ppp_pkg::meta_t   meta1_r, meta1_nxt;
  logic             v2_r;
  ppp_pkg::div_word_t word2_r, word2_nxt;
  ppp_pkg::wide_t   fx, fy;

  always_comb begin
    meta1_nxt.neg_x = point_x[ppp_pkg::COORD_W-1] ^ point_z[ppp_pkg::COORD_W-1];
    meta1_nxt.neg_y = point_y[ppp_pkg::COORD_W-1] ^ point_z[ppp_pkg::COORD_W-1];
    meta1_nxt.zero  = (point_z == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx1_r   <= ppp_pkg::mag_of(point_x);
      my1_r   <= ppp_pkg::mag_of(point_y);
      mz1_r   <= ppp_pkg::mag_of(point_z);
      meta1_r <= meta1_nxt;
    end
  end

  always_comb begin
    fx = ppp_pkg::wide_t'(focal) * ppp_pkg::wide_t'(mx1_r);
    fy = ppp_pkg::wide_t'(focal) * ppp_pkg::wide_t'(my1_r);
    word2_nxt.lx.nq  = fx[ppp_pkg::PROD_W-1:0];
    word2_nxt.lx.rem = '0;
    word2_nxt.ly.nq  = fy[ppp_pkg::PROD_W-1:0];
    word2_nxt.ly.rem = '0;
    word2_nxt.den    = mz1_r;
    word2_nxt.meta   = meta1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word2_r <= word2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_word  = word2_r;

endmodule

FILE: design/ppp_div.sv
// pipelined restoring divider, one quotient bit per stage for both lanes
module ppp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  ppp_pkg::div_word_t in_word,
  output logic               out_valid,
  output ppp_pkg::quo_t      out_quo
);

  localparam int NSTG = ppp_pkg::PROD_W;

  logic               vld_r  [NSTG];
  ppp_pkg::div_word_t word_r [NSTG];
  ppp_pkg::div_word_t word_nxt [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic               vin;
    ppp_pkg::div_word_t win;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign win = in_word;
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign win = word_r[k-1];
    end

    always_comb begin
      word_nxt[k]      = win;
      word_nxt[k].lx   = ppp_pkg::div_step(win.lx, win.den);
      word_nxt[k].ly   = ppp_pkg::div_step(win.ly, win.den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_r[k] <= word_nxt[k];
      end
    end
  end

  assign out_valid    = vld_r[NSTG-1];
  assign out_quo.qx   = word_r[NSTG-1].lx.nq;
  assign out_quo.qy   = word_r[NSTG-1].ly.nq;
  assign out_quo.meta = word_r[NSTG-1].meta;

endmodule

FILE: design/ppp_fix.sv
// sign, center offset, saturation and the output register
module ppp_fix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  ppp_pkg::quo_t    in_quo,
  input  ppp_pkg::coord_t  center_x,
  input  ppp_pkg::coord_t  center_y,
  output logic             out_valid,
  output ppp_pkg::result_t out_res
);

  logic                valid_r;
  ppp_pkg::result_t    res_r, res_nxt;
  ppp_pkg::coord_res_t rx, ry;

  always_comb begin
    rx = ppp_pkg::finish(in_quo.qx, in_quo.meta.neg_x, center_x);
    ry = ppp_pkg::finish(in_quo.qy, in_quo.meta.neg_y, center_y);
    if (in_quo.meta.zero) begin
      res_nxt.proj_x = center_x;
      res_nxt.proj_y = center_y;
      res_nxt.status = ppp_pkg::ST_ZERO;
    end else begin
      res_nxt.proj_x = rx.v;
      res_nxt.proj_y = ry.v;
      res_nxt.status = (rx.sat || ry.sat) ? ppp_pkg::ST_SAT : ppp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: design/perspective_point_projection_unit.sv
// top level: pinhole projection of one 3D point per item, configuration registers
// pipeline: front end, divider, then the output register
// throughput: one item per cycle; the divider spends one stage per quotient bit
// stalls: the whole pipeline holds while the output register is full and not taken
// reset (synchronous, rst_n low): pipeline emptied, focal length 1.0, center zero

`include "assert_macros.svh"

module perspective_point_projection_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  ppp_pkg::cfg_idx_t cfg_index,
  input  ppp_pkg::mag_t     cfg_wdata,
  ppp_point_if.sink         in_point,
  ppp_proj_if.source        out_proj
);

  // configuration registers; the user must write them only while no item is in flight (not enforced)
  ppp_pkg::mag_t   focal_r;
  ppp_pkg::coord_t center_x_r;
  ppp_pkg::coord_t center_y_r;

  // global pipeline advance: output register empty or being drained
  logic               adv;
  logic               mul_vld;
  ppp_pkg::div_word_t mul_word;
  logic               div_vld;
  ppp_pkg::quo_t      div_quo;
  logic               res_vld;
  ppp_pkg::result_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r    <= ppp_pkg::FOCAL_RESET;
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppp_pkg::CFG_FOCAL:    focal_r    <= cfg_wdata;
        ppp_pkg::CFG_CENTER_X: center_x_r <= cfg_wdata;
        ppp_pkg::CFG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign adv            = !res_vld || out_proj.ready;
  assign in_point.ready = adv;

  // magnitudes, signs and zero-depth flag, then focal * |x| and focal * |y|
  ppp_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_point.valid),
    .point_x  (in_point.point_x),
    .point_y  (in_point.point_y),
    .point_z  (in_point.point_z),
    .focal    (focal_r),
    .out_valid(mul_vld),
    .out_word (mul_word)
  );

  // both products divided by |z|, truncated quotient
  ppp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (mul_vld),
    .in_word  (mul_word),
    .out_valid(div_vld),
    .out_quo  (div_quo)
  );

  // sign restore, center add, clamp, status, output register
  ppp_fix u_fix (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (div_vld),
    .in_quo   (div_quo),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .out_valid(res_vld),
    .out_res  (res)
  );

  assign out_proj.valid  = res_vld;
  assign out_proj.proj_x = res.proj_x;
  assign out_proj.proj_y = res.proj_y;
  assign out_proj.status = res.status;

  // zero depth always reports the principal point
  `ASSERT_IMPL(a_zero_gives_center, out_proj.valid && out_proj.status == ppp_pkg::ST_ZERO, out_proj.proj_x == center_x_r && out_proj.proj_y == center_y_r, "zero depth item does not report the center")
  // a saturated item has at least one coordinate at a range limit
  `ASSERT_IMPL(a_sat_at_limit, out_proj.valid && out_proj.status == ppp_pkg::ST_SAT, out_proj.proj_x == ppp_pkg::COORD_MAX || out_proj.proj_x == ppp_pkg::COORD_MIN || out_proj.proj_y == ppp_pkg::COORD_MAX || out_proj.proj_y == ppp_pkg::COORD_MIN, "saturated item without a clamped coordinate")
  // an item leaving the divider while the pipeline moves lands in the output register
  `ASSERT_NEXT(a_div_to_out, div_vld && adv, out_proj.valid, "divider item lost before the output register")

endmodule
